@@ rtl/mmx_pkg.sv @@
// Shared types and constants for the multirotor mixer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mmx_pkg;

  localparam int AXES         = 4;
  localparam int FRAC_BITS    = 12;
  localparam int COEF_W       = 16;
  localparam int DEM_W        = 16;
  localparam int CMD_W        = 16;
  localparam int MOTOR_W      = 3;
  localparam int AXIS_W       = 2;
  localparam int CNT_W        = 4;
  localparam int RESULT_LIMIT = 8;
  localparam int PROD_W       = COEF_W + DEM_W;
  localparam int SUM_W        = PROD_W + 2;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_e;

  // One coefficient write, broadcast to all lanes.
  typedef struct packed {
    logic                     en;
    logic [AXIS_W-1:0]        axis;
    logic [MOTOR_W-1:0]       row;
    logic signed [COEF_W-1:0] coef;
  } coef_wr_t;

  // Control that travels with the lane products into the merge stage.
  typedef struct packed {
    logic               valid;
    logic [MOTOR_W-1:0] motor;
    logic               last;
  } tag_t;

  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

`default_nettype wire

@@ rtl/mmx_lane.sv @@
// One axis lane: holds that axis column of the coefficient table and
// multiplies the selected row by the lane's demand. Depends on mmx_pkg.
`default_nettype none

module mmx_lane
  import mmx_pkg::*;
#(
  parameter int LANE  = 0,
  parameter int SLOTS = 8,
  parameter int ROW_W = 3
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire coef_wr_t                wr_i,
  input  wire logic                    rd_en_i,
  input  wire logic [ROW_W-1:0]        rd_row_i,
  input  wire logic signed [DEM_W-1:0] demand_i,
  output      prod_t                   product_o
);

  logic signed [COEF_W-1:0] column_q [SLOTS];
  prod_t                    product_q;
  logic                     wr_hit;
  logic [ROW_W-1:0]         wr_row;

  assign wr_hit = wr_i.en && (wr_i.axis == AXIS_W'(LANE)) && (32'(wr_i.row) < SLOTS);
  assign wr_row = ROW_W'(wr_i.row);

  // The column resets to zero, as the table does.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        column_q[i] <= '0;
      end
    end else if (wr_hit) begin
      column_q[wr_row] <= wr_i.coef;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      product_q <= column_q[rd_row_i] * demand_i;
    end
  end

  assign product_o = product_q;

endmodule

`default_nettype wire

@@ rtl/mmx_merge.sv @@
// Merge stage: adds the four lane products, shifts out the fraction
// (floor) and saturates into the output register. Depends on mmx_pkg.
`default_nettype none

module mmx_merge
  import mmx_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    advance_i,
  input  wire tag_t                    tag_i,
  input  wire prod_t                   products_i [AXES],
  output      logic                    out_valid_o,
  output      logic [MOTOR_W-1:0]      motor_number_o,
  output      logic signed [CMD_W-1:0] motor_command_o,
  output      logic                    last_o
);

  localparam logic signed [SUM_W-1:0] CmdMax = SUM_W'((2 ** (CMD_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] CmdMin = -SUM_W'(2 ** (CMD_W - 1));

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] shifted;
  logic signed [CMD_W-1:0] cmd;
  logic                    valid_q;
  logic [MOTOR_W-1:0]      motor_q;
  logic signed [CMD_W-1:0] cmd_q;
  logic                    last_q;

  always_comb begin
    sum = '0;
    for (int a = 0; a < AXES; a++) begin
      sum = sum + SUM_W'(products_i[a]);
    end
    shifted = sum >>> FRAC_BITS;
    if (shifted > CmdMax) begin
      cmd = CMD_W'(CmdMax);
    end else if (shifted < CmdMin) begin
      cmd = CMD_W'(CmdMin);
    end else begin
      cmd = CMD_W'(shifted);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= tag_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && tag_i.valid) begin
      motor_q <= tag_i.motor;
      cmd_q   <= cmd;
      last_q  <= tag_i.last;
    end
  end

  assign out_valid_o     = valid_q;
  assign motor_number_o  = motor_q;
  assign motor_command_o = cmd_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

@@ rtl/multirotor_mixer_matvec.sv @@
// Top level of the multirotor mixer: row sequencer, four axis lanes and
// the merge stage. Depends on mmx_pkg, mmx_lane and mmx_merge.
//
//   Channel  Direction  Handshake                  Payload
//   cfg      in         cfg_wr_en_i                cfg_wr_data_i (motor_count)
//   in       in         in_valid_i / in_stall_o    operation_i .. demand_3_i
//   out      out        out_valid_o / out_stall_i  motor_number_o, motor_command_o, last_o
//
// A load transfer writes the coefficient at the edge that takes it. A compute
// transfer holds the input stalled until n motor rows, n being the clamped
// motor count, have issued to all four lanes, one row per cycle while the output
// does not stall; each result passes the lane product registers, then the merge
// output register. The row counter is the limit: one motor command per unstalled cycle.
// Output stalls freeze the lanes, the merge stage and the row counter together.
// Reset clears the coefficient table and sets motor_count to four at once.
`default_nettype none

module multirotor_mixer_matvec
  import mmx_pkg::*;
#(
  parameter int MOTOR_SLOTS = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_wr_en_i,
  input  wire logic [CNT_W-1:0]          cfg_wr_data_i,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic                      operation_i,
  input  wire logic [MOTOR_W-1:0]        motor_index_i,
  input  wire logic [AXIS_W-1:0]         axis_index_i,
  input  wire logic signed [COEF_W-1:0]  coefficient_i,
  input  wire logic signed [DEM_W-1:0]   demand_0_i,
  input  wire logic signed [DEM_W-1:0]   demand_1_i,
  input  wire logic signed [DEM_W-1:0]   demand_2_i,
  input  wire logic signed [DEM_W-1:0]   demand_3_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic [MOTOR_W-1:0]        motor_number_o,
  output      logic signed [CMD_W-1:0]   motor_command_o,
  output      logic                      last_o
);

  localparam int ROW_W     = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
  localparam int RUN_LIMIT = (MOTOR_SLOTS < RESULT_LIMIT) ? MOTOR_SLOTS : RESULT_LIMIT;

  logic [CNT_W-1:0]        motor_count_q;
  logic                    run_q, run_d;
  logic [ROW_W-1:0]        row_q, row_d;
  logic [CNT_W-1:0]        n_q, n_d;
  logic [CNT_W-1:0]        n_lim;
  logic signed [DEM_W-1:0] demand_q [AXES];
  tag_t                    tag_q;
  coef_wr_t                coef_wr;
  prod_t                   products [AXES];
  logic                    in_xfer;
  logic                    compute_xfer;
  logic                    advance;
  logic                    issue;
  logic                    last_row;

  // The input is held off only while motor rows are still being issued.
  assign in_stall_o   = run_q;
  assign in_xfer      = in_valid_i && !run_q;
  assign compute_xfer = in_xfer && (op_e'(operation_i) == OP_COMPUTE);

  assign coef_wr.en   = in_xfer && (op_e'(operation_i) == OP_LOAD);
  assign coef_wr.axis = axis_index_i;
  assign coef_wr.row  = motor_index_i;
  assign coef_wr.coef = coefficient_i;

  // The whole result pipeline moves when the output register is free.
  assign advance  = !out_valid_o || !out_stall_i;
  assign issue    = run_q && advance;
  assign last_row = ((CNT_W'(row_q) + CNT_W'(1)) == n_q);

  // Motor counts above the table size or the result limit are clamped.
  assign n_lim = (motor_count_q > CNT_W'(RUN_LIMIT)) ? CNT_W'(RUN_LIMIT) : motor_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_count_q <= CNT_W'(4);
    end else if (cfg_wr_en_i) begin
      motor_count_q <= cfg_wr_data_i;
    end
  end

  // Row sequencer: a zero motor count starts no run at all.
  always_comb begin
    run_d = run_q;
    row_d = row_q;
    n_d   = n_q;
    if (issue) begin
      if (last_row) begin
        run_d = 1'b0;
      end else begin
        row_d = row_q + ROW_W'(1);
      end
    end
    if (compute_xfer) begin
      run_d = (n_lim != '0);
      row_d = '0;
      n_d   = n_lim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      row_q <= '0;
      n_q   <= '0;
    end else begin
      run_q <= run_d;
      row_q <= row_d;
      n_q   <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (compute_xfer) begin
      demand_q[0] <= demand_0_i;
      demand_q[1] <= demand_1_i;
      demand_q[2] <= demand_2_i;
      demand_q[3] <= demand_3_i;
    end
  end

  // The tag follows the products that the lanes register on the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (advance) begin
      tag_q.valid <= issue;
      tag_q.motor <= MOTOR_W'(row_q);
      tag_q.last  <= last_row;
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    mmx_lane #(
      .LANE  (a),
      .SLOTS (MOTOR_SLOTS),
      .ROW_W (ROW_W)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_i      (coef_wr),
      .rd_en_i   (issue),
      .rd_row_i  (row_q),
      .demand_i  (demand_q[a]),
      .product_o (products[a])
    );
  end

  mmx_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .tag_i           (tag_q),
    .products_i      (products),
    .out_valid_o     (out_valid_o),
    .motor_number_o  (motor_number_o),
    .motor_command_o (motor_command_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

@@ rtl/mmx_checker.sv @@
// Port-level checks for the multirotor mixer, bound to the top level.
// Depends on mmx_pkg.
`default_nettype none

module mmx_checker
  import mmx_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire logic                      operation_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic [MOTOR_W-1:0]        motor_number_o,
  input wire logic signed [CMD_W-1:0]   motor_command_o,
  input wire logic                      last_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(motor_number_o)
      && $stable(motor_command_o) && $stable(last_o))
    else $error("stalled result changed");

  // The input stalls only right after a compute transfer.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o && operation_i))
    else $error("input stall without a compute transfer");

  // Once a non-final command is taken, the next command of its run is ready.
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a run of commands");

  // A load never stalls the input.
  a_load_nostall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !operation_i |=> !in_stall_o)
    else $error("input stalled after a load");

endmodule

bind multirotor_mixer_matvec mmx_checker u_mmx_checker (.*);

`default_nettype wire
